[src/mpd_pkg.sv]
// Shared types, constants and the Morse code table of the pulse decoder.
package mpd_pkg;

    localparam int unsigned MAX_SYMBOLS_DEF = 5;
    localparam int unsigned FIFO_DEPTH_DEF  = 2;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned CODE_BITS = 5;
    localparam int unsigned LEN_BITS  = 3;
    localparam int unsigned CODE_MAX_LEN = 5;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [1:0] REG_DOT_MIN    = 2'd0;
    localparam logic [1:0] REG_DOT_MAX    = 2'd1;
    localparam logic [1:0] REG_LETTER_GAP = 2'd2;

    localparam logic [TIME_W-1:0] DOT_MIN_RST    = 32'd1875;
    localparam logic [TIME_W-1:0] DOT_MAX_RST    = 32'd12500;
    localparam logic [TIME_W-1:0] LETTER_GAP_RST = 32'd25000;

    typedef struct packed {
        logic [TIME_W-1:0] dot_min;
        logic [TIME_W-1:0] dot_max;
        logic [TIME_W-1:0] letter_gap;
    } t_cfg;

    typedef enum logic {
        CMD_SYMBOL,
        CMD_END
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      dash;
    } t_cmd;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] ascii;
    } t_lookup;

    // symbol i of a code sits in bit i: dot 0, dash 1
    function automatic t_lookup morse_lookup(input logic [LEN_BITS-1:0]  len,
                                             input logic [CODE_BITS-1:0] bits);
        t_lookup res;
        res.hit = 1'b1;
        unique case ({len, bits})
            {3'd2, 5'd2}:  res.ascii = 7'd65;
            {3'd4, 5'd1}:  res.ascii = 7'd66;
            {3'd4, 5'd5}:  res.ascii = 7'd67;
            {3'd3, 5'd1}:  res.ascii = 7'd68;
            {3'd1, 5'd0}:  res.ascii = 7'd69;
            {3'd4, 5'd4}:  res.ascii = 7'd70;
            {3'd3, 5'd3}:  res.ascii = 7'd71;
            {3'd4, 5'd0}:  res.ascii = 7'd72;
            {3'd2, 5'd0}:  res.ascii = 7'd73;
            {3'd4, 5'd14}: res.ascii = 7'd74;
            {3'd3, 5'd5}:  res.ascii = 7'd75;
            {3'd4, 5'd2}:  res.ascii = 7'd76;
            {3'd2, 5'd3}:  res.ascii = 7'd77;
            {3'd2, 5'd1}:  res.ascii = 7'd78;
            {3'd3, 5'd7}:  res.ascii = 7'd79;
            {3'd4, 5'd6}:  res.ascii = 7'd80;
            {3'd4, 5'd11}: res.ascii = 7'd81;
            {3'd3, 5'd2}:  res.ascii = 7'd82;
            {3'd3, 5'd0}:  res.ascii = 7'd83;
            {3'd1, 5'd1}:  res.ascii = 7'd84;
            {3'd3, 5'd4}:  res.ascii = 7'd85;
            {3'd4, 5'd8}:  res.ascii = 7'd86;
            {3'd3, 5'd6}:  res.ascii = 7'd87;
            {3'd4, 5'd9}:  res.ascii = 7'd88;
            {3'd4, 5'd13}: res.ascii = 7'd89;
            {3'd4, 5'd3}:  res.ascii = 7'd90;
            {3'd5, 5'd30}: res.ascii = 7'd49;
            {3'd5, 5'd28}: res.ascii = 7'd50;
            {3'd5, 5'd24}: res.ascii = 7'd51;
            {3'd5, 5'd16}: res.ascii = 7'd52;
            {3'd5, 5'd0}:  res.ascii = 7'd53;
            {3'd5, 5'd1}:  res.ascii = 7'd54;
            {3'd5, 5'd3}:  res.ascii = 7'd55;
            {3'd5, 5'd7}:  res.ascii = 7'd56;
            {3'd5, 5'd15}: res.ascii = 7'd57;
            {3'd5, 5'd31}: res.ascii = 7'd48;
            default: begin
                res.hit   = 1'b0;
                res.ascii = '0;
            end
        endcase
        return res;
    endfunction

endpackage

[src/morse_pulse_decoder_core.sv]
// Morse pulse decoder top level: configuration registers and the front, queue and back ends.
//
// Input stream: one key edge per transfer. tuser carries the key level (1 press, 0 release),
// tdata the 32-bit tick count at the edge. A release turns the press width into a dot or a
// dash; a press after a gap above letter_gap_ticks ends the letter.
// Output stream: one ASCII character per decoded letter or digit; unknown, empty or
// over-long patterns give no transfer.
// Configuration over APB: dot_min_ticks at 0x0, dot_max_ticks at 0x4, letter_gap_ticks at 0x8.
// The press that ends a letter passes the queue and the back end before its character is offered.
// Throughput: one edge per cycle while the queue has room; the front end measures and compares
// combinationally, and the back end updates the pattern and performs the table look-up as it pops.
// Reset clears the times, the pattern, the queue and the output valid flag and loads the
// default thresholds. When the receiver stalls the output register holds its character, the
// back end stops and the default two-entry queue fills; the input stays ready until it is full.
module morse_pulse_decoder_core #(
    parameter int unsigned MAX_SYMBOLS = mpd_pkg::MAX_SYMBOLS_DEF,
    parameter int unsigned FIFO_DEPTH  = mpd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [mpd_pkg::TIME_W-1:0]        i_s_axis_tdata,  // [31:0] edge_time
    input  logic                              i_s_axis_tuser,  // [0] key_level
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // [6:0] character, [7] zero
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mpd_pkg::*;

    t_cfg              r_cfg;
    logic              cfg_write;
    logic [1:0]        reg_index;
    logic              q_ready;
    logic              q_push;
    t_cmd              q_in;
    logic              q_valid;
    logic              q_pop;
    t_cmd              q_out;
    logic [CHAR_W-1:0] out_char;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_comb begin
        unique case (reg_index)
            REG_DOT_MIN:    prdata = r_cfg.dot_min;
            REG_DOT_MAX:    prdata = r_cfg.dot_max;
            REG_LETTER_GAP: prdata = r_cfg.letter_gap;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_min    <= DOT_MIN_RST;
            r_cfg.dot_max    <= DOT_MAX_RST;
            r_cfg.letter_gap <= LETTER_GAP_RST;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_DOT_MIN:    r_cfg.dot_min    <= pwdata;
                REG_DOT_MAX:    r_cfg.dot_max    <= pwdata;
                REG_LETTER_GAP: r_cfg.letter_gap <= pwdata;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    mpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_level   (i_s_axis_tuser),
        .i_time    (i_s_axis_tdata),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    mpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    mpd_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_cmd   (q_out),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (out_char)
    );

    assign o_m_axis_tdata = {1'b0, out_char};

endmodule

[src/mpd_front.sv]
// Front end: accepts key edges, measures widths and gaps, issues symbol and end commands.
module mpd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_level,
    input  logic [mpd_pkg::TIME_W-1:0] i_time,
    input  mpd_pkg::t_cfg         i_cfg,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output mpd_pkg::t_cmd         o_cmd
);
    import mpd_pkg::*;

    logic [TIME_W-1:0] r_press_time;
    logic [TIME_W-1:0] r_release_time;
    logic [TIME_W-1:0] width;
    logic [TIME_W-1:0] gap;
    logic              accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign width   = i_time - r_press_time;
    assign gap     = i_time - r_release_time;

    always_comb begin
        o_cmd.kind = i_level ? CMD_END : CMD_SYMBOL;
        o_cmd.dash = !((width > i_cfg.dot_min) && (width < i_cfg.dot_max));
        // a short gap only records the press time
        o_push     = accept && (!i_level || (gap > i_cfg.letter_gap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time   <= '0;
            r_release_time <= '0;
        end else if (accept) begin
            if (i_level) begin
                r_press_time <= i_time;
            end else begin
                r_release_time <= i_time;
            end
        end
    end

endmodule

[src/mpd_fifo.sv]
// Short command queue between the front end and the pattern back end.
module mpd_fifo #(
    parameter int unsigned DEPTH = mpd_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpd_pkg::t_cmd i_data,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output mpd_pkg::t_cmd o_data
);
    import mpd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/mpd_back.sv]
// Back end: builds the symbol pattern, looks up letters and holds the output register.
module mpd_back #(
    parameter int unsigned MAX_SYMBOLS = mpd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_pop,
    input  mpd_pkg::t_cmd               i_cmd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mpd_pkg::CHAR_W-1:0]  o_char
);
    import mpd_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_SYMBOLS + 2);

    logic [MAX_SYMBOLS-1:0] r_bits;
    logic [MAX_SYMBOLS-1:0] n_bits;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic                   r_valid;
    logic                   n_valid;
    logic [CHAR_W-1:0]      r_char;
    logic [CHAR_W-1:0]      n_char;
    logic                   advance;
    logic                   len_ok;
    t_lookup                found;

    assign advance = !r_valid || i_ready;
    assign o_pop   = i_valid && advance;
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign len_ok  = (r_len != '0) && (r_len <= LEN_W'(CODE_MAX_LEN));
    assign found   = morse_lookup(len_ok ? LEN_BITS'(r_len) : '0, CODE_BITS'(r_bits));

    always_comb begin
        n_bits  = r_bits;
        n_len   = r_len;
        n_char  = r_char;
        n_valid = advance ? 1'b0 : r_valid;
        if (o_pop) begin
            unique case (i_cmd.kind)
                CMD_SYMBOL: begin
                    if (r_len < LEN_W'(MAX_SYMBOLS)) begin
                        for (int i = 0; i < MAX_SYMBOLS; i++) begin
                            if (r_len == LEN_W'(i)) begin
                                n_bits[i] = i_cmd.dash;
                            end
                        end
                        n_len = r_len + LEN_W'(1);
                    end else begin
                        n_len = LEN_W'(MAX_SYMBOLS + 1);
                    end
                end
                CMD_END: begin
                    n_bits = '0;
                    n_len  = '0;
                    if (len_ok && found.hit) begin
                        n_valid = 1'b1;
                        n_char  = found.ascii;
                    end
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_bits  <= n_bits;
            r_len   <= n_len;
            r_valid <= n_valid;
        end
    end

endmodule
